>>> rtl/core/cgtc_pkg.sv
// Shared types, constants and the month table of the civil/GPS time converter.
// Used by both conversion pipelines and the top level; depends on nothing else.
package cgtc_pkg;

  typedef struct packed {
    logic        req_type;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] second_ms;
    logic [13:0] gps_week;
    logic [29:0] week_ms;
  } in_item_t;

  typedef struct packed {
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_second_ms;
    logic [13:0] out_gps_week;
    logic [29:0] out_week_ms;
    logic        out_of_range;
  } out_item_t;

  localparam logic REQ_CIVIL_TO_GPS = 1'b0;
  localparam logic REQ_GPS_TO_CIVIL = 1'b1;

  localparam int PIPE_DEPTH = 6;

  localparam logic [26:0] MS_PER_DAY    = 27'd86400000;
  localparam logic [21:0] MS_PER_HOUR   = 22'd3600000;
  localparam logic [16:0] MS_PER_MINUTE = 17'd60000;
  localparam logic [17:0] MAX_WEEK      = 18'd11479;
  localparam logic [15:0] GPS_EPOCH_MJD = 16'd44244;

  localparam logic signed [22:0] CIVIL_DAY_OFFSET = 23'sd723263;
  localparam logic [21:0]        JD_OFFSET        = 22'd2401538;
  localparam logic [11:0]        CENTURY_OFFSET   = 12'd2442;
  localparam logic [13:0]        YEAR_OFFSET      = 14'd4715;

  localparam logic [20:0] RECIP_WEEKDAY = 21'(((64'd1 << 23) + 64'd6) / 64'd7);
  localparam logic [30:0] RECIP_DAY     =
    31'(((64'd1 << 57) + 64'd86399999) / 64'd86400000);
  localparam logic [26:0] RECIP_YEAR    = 27'(((64'd1 << 39) + 64'd7304) / 64'd7305);
  localparam logic [27:0] RECIP_HOUR    =
    28'(((64'd1 << 49) + 64'd3599999) / 64'd3600000);
  localparam logic [22:0] RECIP_MINUTE  = 23'(((64'd1 << 38) + 64'd59999) / 64'd60000);
  localparam logic [25:0] RECIP_MONTH   =
    26'(((64'd10000 << 30) + 64'd306000) / 64'd306001);

  // Integer part of 30.6001 * k for the month index k of the Meeus formulas.
  function automatic logic [9:0] month_days(input logic [4:0] k);
    logic [9:0] v;
    case (k)
      5'd1:    v = 10'd30;
      5'd2:    v = 10'd61;
      5'd3:    v = 10'd91;
      5'd4:    v = 10'd122;
      5'd5:    v = 10'd153;
      5'd6:    v = 10'd183;
      5'd7:    v = 10'd214;
      5'd8:    v = 10'd244;
      5'd9:    v = 10'd275;
      5'd10:   v = 10'd306;
      5'd11:   v = 10'd336;
      5'd12:   v = 10'd367;
      5'd13:   v = 10'd397;
      5'd14:   v = 10'd428;
      5'd15:   v = 10'd459;
      5'd16:   v = 10'd489;
      5'd17:   v = 10'd520;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/cgtc_civil_to_gps.sv
// Civil date and time to GPS week and milliseconds of week, six register stages.
// Depends on cgtc_pkg for the item types, constants and month table.
module cgtc_civil_to_gps import cgtc_pkg::*; (
  input  logic      clk,
  input  in_item_t  in_data,
  output out_item_t res
);

  logic               early;
  logic signed [12:0] y;
  logic [3:0]         m;
  logic signed [24:0] a_prod;
  logic [26:0]        tod;

  logic signed [22:0] a_r;
  logic [9:0]         b_r;
  logic [4:0]         day_r;
  logic [26:0]        tod_r;

  logic signed [22:0] dd;
  logic               dtod;
  logic signed [22:0] dn_nxt;
  logic [26:0]        rem_nxt;
  logic signed [22:0] dn_r;
  logic [26:0]        rem_r;

  logic [19:0]        du;
  logic [40:0]        q_prod;
  logic [17:0]        q_r;
  logic [19:0]        du_r;
  logic               neg_r;
  logic [26:0]        rem3_r;

  logic [2:0]         dow;
  logic               oor;
  logic [29:0]        wms;
  out_item_t          res4_nxt;
  out_item_t          res4_r;
  out_item_t          res5_r;
  out_item_t          res_r;

  assign early  = in_data.month <= 4'd2;
  assign y      = early ? $signed({1'b0, in_data.year}) - 13'sd1
                        : $signed({1'b0, in_data.year});
  assign m      = early ? in_data.month + 4'd12 : in_data.month;
  assign a_prod = 25'(y) * 25'sd1461;
  assign tod    = 27'(in_data.hour) * 27'(MS_PER_HOUR)
                + 27'(in_data.minute) * 27'(MS_PER_MINUTE)
                + 27'(in_data.second_ms);

  always_ff @(posedge clk) begin
    a_r   <= 23'(a_prod >>> 2);
    b_r   <= month_days(5'(m) + 5'd1);
    day_r <= in_data.day;
    tod_r <= tod;
  end

  assign dd      = a_r + $signed({13'd0, b_r}) + $signed({18'd0, day_r}) - CIVIL_DAY_OFFSET;
  assign dtod    = tod_r >= MS_PER_DAY;
  assign dn_nxt  = dd + $signed({22'd0, dtod});
  assign rem_nxt = dtod ? tod_r - MS_PER_DAY : tod_r;

  always_ff @(posedge clk) begin
    dn_r  <= dn_nxt;
    rem_r <= rem_nxt;
  end

  assign du     = dn_r[19:0];
  assign q_prod = 41'(du) * 41'(RECIP_WEEKDAY);

  always_ff @(posedge clk) begin
    q_r    <= q_prod[40:23];
    du_r   <= du;
    neg_r  <= dn_r[22];
    rem3_r <= rem_r;
  end

  assign dow = 3'(du_r - 20'(q_r) * 20'd7);
  assign oor = neg_r | (q_r > MAX_WEEK);
  assign wms = 30'(dow) * 30'(MS_PER_DAY) + 30'(rem3_r);

  always_comb begin
    res4_nxt = '0;
    res4_nxt.out_of_range = oor;
    if (!oor) begin
      res4_nxt.out_gps_week = 14'(q_r);
      res4_nxt.out_week_ms  = wms;
    end
  end

  // The last two stages align this path with the GPS-to-civil path.
  always_ff @(posedge clk) begin
    res4_r <= res4_nxt;
    res5_r <= res4_r;
    res_r  <= res5_r;
  end

  assign res = res_r;

endmodule

>>> rtl/core/cgtc_gps_to_civil.sv
// GPS week and milliseconds of week to civil date and time, six register stages.
// Depends on cgtc_pkg for the item types, constants and month table.
module cgtc_gps_to_civil import cgtc_pkg::*; (
  input  logic      clk,
  input  in_item_t  in_data,
  output out_item_t res
);

  logic [60:0] qd_prod;
  logic [3:0]  qd_r;
  logic [29:0] wms_r;
  logic [17:0] days_r;

  logic [21:0] b;
  logic [25:0] n_r;
  logic [21:0] b_r;
  logic [26:0] tod_r;

  logic [52:0] c_prod;
  logic [54:0] h_prod;
  logic [13:0] c_r;
  logic [21:0] b3_r;
  logic [4:0]  hour_r;
  logic [26:0] tod3_r;

  logic [24:0] d_prod;
  logic [22:0] d;
  logic [9:0]  x_r;
  logic [13:0] c4_r;
  logic [21:0] rem1_r;
  logic [4:0]  hour4_r;

  logic [35:0] e_prod;
  logic [44:0] m_prod;
  logic [4:0]  e_r;
  logic [9:0]  x5_r;
  logic [13:0] c5_r;
  logic [21:0] rem1_5_r;
  logic [4:0]  hour5_r;
  logic [5:0]  minute_r;

  logic [4:0]  mon;
  logic        adj;
  out_item_t   res_nxt;
  out_item_t   res_r;

  assign qd_prod = 61'(in_data.week_ms) * 61'(RECIP_DAY);

  always_ff @(posedge clk) begin
    qd_r   <= 4'(qd_prod >> 57);
    wms_r  <= in_data.week_ms;
    days_r <= 18'(GPS_EPOCH_MJD) + 18'(in_data.gps_week) * 18'd7;
  end

  assign b = 22'(days_r) + 22'(qd_r) + JD_OFFSET;

  always_ff @(posedge clk) begin
    tod_r <= 27'(wms_r - 30'(qd_r) * 30'(MS_PER_DAY));
    b_r   <= b;
    n_r   <= 26'(b) * 26'd20 - 26'(CENTURY_OFFSET);
  end

  assign c_prod = 53'(n_r) * 53'(RECIP_YEAR);
  assign h_prod = 55'(tod_r) * 55'(RECIP_HOUR);

  always_ff @(posedge clk) begin
    c_r    <= 14'(c_prod >> 39);
    b3_r   <= b_r;
    hour_r <= 5'(h_prod >> 49);
    tod3_r <= tod_r;
  end

  assign d_prod = 25'(c_r) * 25'd1461;
  assign d      = 23'(d_prod >> 2);

  always_ff @(posedge clk) begin
    x_r     <= 10'(23'(b3_r) - d);
    c4_r    <= c_r;
    rem1_r  <= 22'(tod3_r - 27'(hour_r) * 27'(MS_PER_HOUR));
    hour4_r <= hour_r;
  end

  assign e_prod = 36'(x_r) * 36'(RECIP_MONTH);
  assign m_prod = 45'(rem1_r) * 45'(RECIP_MINUTE);

  always_ff @(posedge clk) begin
    e_r      <= 5'(e_prod >> 30);
    x5_r     <= x_r;
    c5_r     <= c4_r;
    rem1_5_r <= rem1_r;
    hour5_r  <= hour4_r;
    minute_r <= 6'(m_prod >> 38);
  end

  assign mon = (e_r >= 5'd14) ? e_r - 5'd13 : e_r - 5'd1;
  assign adj = mon >= 5'd3;

  always_comb begin
    res_nxt               = '0;
    res_nxt.out_year      = 12'(c5_r - YEAR_OFFSET - 14'(adj));
    res_nxt.out_month     = 4'(mon);
    res_nxt.out_day       = 5'(x5_r - month_days(e_r));
    res_nxt.out_hour      = hour5_r;
    res_nxt.out_minute    = minute_r;
    res_nxt.out_second_ms = 16'(rem1_5_r - 22'(minute_r) * 22'(MS_PER_MINUTE));
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

>>> rtl/core/civil_gps_time_converter_top.sv
// Top level of the civil/GPS time converter: both conversion pipelines and the result select.
// Depends on cgtc_pkg, cgtc_civil_to_gps and cgtc_gps_to_civil.
//
//   channel  ports                      direction  transaction
//   input    start, busy, in_data       in         start high while busy is low
//   result   out_valid, out_data        out        out_valid high for one cycle
//
// One transaction is accepted every cycle; busy is always low.
// Each result passes through the six stages of the conversion pipelines, set by the
// reciprocal multiplications of the GPS-to-civil path, and then one output register.
// Reset clears the valid bits only; results cannot be held off by the receiver.
module civil_gps_time_converter_top import cgtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  logic                  accept;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic [PIPE_DEPTH-1:0] typ_r;
  out_item_t             c2g_res;
  out_item_t             g2c_res;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  cgtc_civil_to_gps u_c2g (
    .clk     (clk),
    .in_data (in_data),
    .res     (c2g_res)
  );

  cgtc_gps_to_civil u_g2c (
    .clk     (clk),
    .in_data (in_data),
    .res     (g2c_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], accept};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    typ_r      <= {typ_r[PIPE_DEPTH-2:0], in_data.req_type};
    out_data_r <= (typ_r[PIPE_DEPTH-1] == REQ_GPS_TO_CIVIL) ? g2c_res : c2g_res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of civil_gps_time_converter_top: both conversion directions.
// Depends on cgtc_pkg and the converter RTL; expected results come from a predictor below.

module tb;
  import cgtc_pkg::*;

  localparam longint MS_DAY    = 86400000;
  localparam longint MS_WEEK   = 604800000;
  localparam longint EPOCH_MJD = 44244;
  localparam longint LAST_WEEK = 11479;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_valid;
  out_item_t out_data;

  out_item_t pending_results[$];
  int        mismatch_count;
  bit        no_idle;

  civil_gps_time_converter_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic longint floor_quot(input longint n, input longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) begin
      q = q - 1;
    end
    return q;
  endfunction

  function automatic out_item_t convert_time(input in_item_t req);
    out_item_t res;
    longint    yr, mo, dd, hh, mi, ss, mjd, total, week, wms, days, tod;
    longint    b, c, d, e, dom, mon;
    res = '0;
    if (req.req_type == REQ_CIVIL_TO_GPS) begin
      yr = longint'(req.year);
      mo = longint'(req.month);
      dd = longint'(req.day);
      hh = longint'(req.hour);
      mi = longint'(req.minute);
      ss = longint'(req.second_ms);
      if (mo <= 2) begin
        yr = yr - 1;
        mo = mo + 12;
      end
      mjd = floor_quot(1461 * yr, 4) + floor_quot(306001 * (mo + 1), 10000) + dd - 679019;
      total = (mjd - EPOCH_MJD) * MS_DAY + hh * 3600000 + mi * 60000 + ss;
      if (total < 0 || total / MS_WEEK > LAST_WEEK) begin
        res.out_of_range = 1'b1;
      end else begin
        week = total / MS_WEEK;
        res.out_gps_week = week[13:0];
        res.out_week_ms = 30'(total % MS_WEEK);
      end
    end else begin
      week = longint'(req.gps_week);
      wms = longint'(req.week_ms);
      days = EPOCH_MJD + week * 7 + wms / MS_DAY;
      tod = wms % MS_DAY;
      b = days + 2400001 + 1537;
      c = floor_quot(20 * b - 2442, 7305);
      d = floor_quot(1461 * c, 4);
      e = floor_quot(10000 * (b - d), 306001);
      dom = b - d - floor_quot(306001 * e, 10000);
      mon = e - 1 - 12 * (e / 14);
      yr = c - 4715 - (7 + mon) / 10;
      res.out_year = yr[11:0];
      res.out_month = mon[3:0];
      res.out_day = dom[4:0];
      res.out_hour = 5'(tod / 3600000);
      res.out_minute = 6'((tod % 3600000) / 60000);
      res.out_second_ms = 16'(tod % 60000);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatch_count++;
      $display("%0t %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && start && !busy) begin
      pending_results.push_back(convert_time(in_data));
    end
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected result, expected none actual %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("out_year", 32'(want.out_year), 32'(out_data.out_year));
        check_field("out_month", 32'(want.out_month), 32'(out_data.out_month));
        check_field("out_day", 32'(want.out_day), 32'(out_data.out_day));
        check_field("out_hour", 32'(want.out_hour), 32'(out_data.out_hour));
        check_field("out_minute", 32'(want.out_minute), 32'(out_data.out_minute));
        check_field("out_second_ms", 32'(want.out_second_ms),
                    32'(out_data.out_second_ms));
        check_field("out_gps_week", 32'(want.out_gps_week), 32'(out_data.out_gps_week));
        check_field("out_week_ms", 32'(want.out_week_ms), 32'(out_data.out_week_ms));
        check_field("out_of_range", 32'(want.out_of_range), 32'(out_data.out_of_range));
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send_request(input in_item_t req);
    int gap;
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t random_request(input bit civil, input bit wild);
    in_item_t r;
    r.req_type = civil ? REQ_CIVIL_TO_GPS : REQ_GPS_TO_CIVIL;
    r.year = 12'($urandom_range(0, 4095));
    r.month = 4'($urandom_range(0, 15));
    r.day = 5'($urandom_range(0, 31));
    r.hour = 5'($urandom_range(0, 31));
    r.minute = 6'($urandom_range(0, 63));
    r.second_ms = 16'($urandom_range(0, 65535));
    r.gps_week = 14'($urandom_range(0, 16383));
    r.week_ms = 30'($urandom_range(0, 1073741823));
    if (!wild) begin
      if (civil) begin
        r.year = 12'($urandom_range(1980, 2200));
        r.month = 4'($urandom_range(1, 12));
        r.day = 5'($urandom_range(1, 31));
        r.hour = 5'($urandom_range(0, 23));
        r.minute = 6'($urandom_range(0, 59));
        r.second_ms = 16'($urandom_range(0, 59999));
      end else begin
        r.gps_week = 14'($urandom_range(0, 11479));
        r.week_ms = 30'($urandom_range(0, 604799999));
      end
    end
    return r;
  endfunction

  function automatic in_item_t civil_request(input int yr, input int mo, input int dd,
                                             input int hh, input int mi, input int ss);
    in_item_t r;
    r = random_request(1'b1, 1'b1);
    r.year = 12'(yr);
    r.month = 4'(mo);
    r.day = 5'(dd);
    r.hour = 5'(hh);
    r.minute = 6'(mi);
    r.second_ms = 16'(ss);
    return r;
  endfunction

  function automatic in_item_t gps_request(input int week, input int wms);
    in_item_t r;
    r = random_request(1'b0, 1'b1);
    r.gps_week = 14'(week);
    r.week_ms = 30'(wms);
    return r;
  endfunction

  task automatic test_civil_edges();
    send_request(civil_request(1980, 1, 6, 0, 0, 0));
    send_request(civil_request(1980, 1, 5, 23, 59, 59999));
    send_request(civil_request(1980, 1, 6, 0, 0, 1));
    send_request(civil_request(0, 0, 0, 0, 0, 0));
    send_request(civil_request(4095, 15, 31, 31, 63, 65535));
    send_request(civil_request(2200, 1, 1, 0, 0, 0));
    send_request(civil_request(2200, 12, 31, 23, 59, 59999));
    send_request(civil_request(2000, 2, 29, 12, 30, 30000));
    send_request(civil_request(2024, 3, 1, 0, 0, 0));
    send_request(civil_request(1999, 12, 31, 23, 59, 60000));
    send_request(civil_request(2024, 13, 1, 0, 0, 0));
    send_request(civil_request(2021, 2, 30, 24, 60, 0));
  endtask

  task automatic test_gps_edges();
    send_request(gps_request(0, 0));
    send_request(gps_request(0, 604799999));
    send_request(gps_request(0, 1073741823));
    send_request(gps_request(11479, 604799999));
    send_request(gps_request(16383, 1073741823));
    send_request(gps_request(1023, 604799999));
    send_request(gps_request(1024, 0));
    send_request(gps_request(2047, 86399999));
    send_request(gps_request(2048, 86400000));
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 400; i++) begin
      if (i % 40 == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (i == 200) begin
        wait_for_results();
      end
      send_request(random_request(1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0));
    end
  endtask

  initial begin
    mismatch_count = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_civil_edges();
    test_gps_edges();
    test_random_traffic();
    wait_for_results();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0t %0d expected results never arrived", $time, pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
